>>> rtl/core/pfp_pkg.sv
package pfp_pkg;

  // Size of the body buffer in bytes; the body length saturates one below it.
  localparam int unsigned BUFFER_BYTES = 32;
  localparam int unsigned LEN_W        = $clog2(BUFFER_BYTES);

  // Field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CIDX_W  = 2;

  // APB port geometry.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Frame bytes.
  localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'hFF;
  localparam logic [BYTE_W-1:0] KIND_CORNER  = 8'h01;
  localparam logic [BYTE_W-1:0] KIND_CURRENT = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE     = 8'hFE;

  // Reset values of the coordinate limits.
  localparam logic [COORD_W-1:0] X_LIMIT_RESET = 16'd350;
  localparam logic [COORD_W-1:0] Y_LIMIT_RESET = 16'd250;

  // Register indexes, taken from byte address bit 2.
  localparam logic REG_X_LIMIT = 1'b0;
  localparam logic REG_Y_LIMIT = 1'b1;

  // Point kinds as carried in the result.
  localparam logic KIND_BIT_CURRENT = 1'b0;
  localparam logic KIND_BIT_CORNER  = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_KIND = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

endpackage

>>> rtl/core/pfp_in_if.sv
interface pfp_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfp_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/pfp_out_if.sv
interface pfp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         point_kind;
  logic [pfp_pkg::COORD_W-1:0]  point_x;
  logic [pfp_pkg::COORD_W-1:0]  point_y;
  logic                         accepted;
  logic [pfp_pkg::CIDX_W-1:0]   corner_index;

  modport source (output valid, output point_kind, output point_x, output point_y,
                  output accepted, output corner_index, input ready);
  modport sink   (input valid, input point_kind, input point_x, input point_y,
                  input accepted, input corner_index, output ready);
endinterface

>>> rtl/core/point_frame_parser.sv
// Channel   Direction  Transfer moves
// in_ch     sink       one received byte (rx_byte)
// out_ch    source     one point (kind, x, y, accepted, corner index)
// cfg_*     APB slave  x_limit at address 0, y_limit at address 4
//
// Each byte is held in the input register and parsed from there; a new byte
// can be taken every cycle while no closing byte waits. A finished point sits
// in the output register until transferred, and only a frame-closing byte
// waits for it, so other bytes keep flowing while a point is held. Reset is
// synchronous and returns to hunting for a header with limits 350 and 250.
module point_frame_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  pfp_in_if.sink                             in_ch,
  pfp_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pfp_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  logic [pfp_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [pfp_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import pfp_pkg::*;

  // Configuration registers.
  logic [COORD_W-1:0] x_limit_r;
  logic [COORD_W-1:0] y_limit_r;
  logic               cfg_wr;
  logic               cfg_sel;

  // Input register.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Parser state.
  phase_t            phase_r, phase_nxt;
  logic              frame_kind_r, frame_kind_nxt;
  logic [BYTE_W-1:0] prev_byte_r;
  logic [LEN_W-1:0]  body_len_r, body_len_nxt;
  logic [BYTE_W-1:0] body_r [4];
  logic [BYTE_W-1:0] body_nxt [4];
  logic [CIDX_W-1:0] corner_cnt_r, corner_cnt_nxt;

  // Output register.
  logic               out_valid_r;
  logic               out_kind_r;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  logic               out_acc_r;
  logic [CIDX_W-1:0]  out_cidx_r;

  logic               frame_end;
  logic               out_free;
  logic               s1_fire;
  logic               in_fire;
  logic               len_short;
  logic [BYTE_W-1:0]  view [4];
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic               cur_ok;

  // APB register port.
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_sel)
      REG_X_LIMIT: cfg_prdata = APB_DATA_W'(x_limit_r);
      default:     cfg_prdata = APB_DATA_W'(y_limit_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RESET;
      y_limit_r <= Y_LIMIT_RESET;
    end else if (cfg_wr) begin
      if (cfg_sel == REG_X_LIMIT) begin
        x_limit_r <= cfg_pwdata[COORD_W-1:0];
      end else begin
        y_limit_r <= cfg_pwdata[COORD_W-1:0];
      end
    end
  end

  // Handshake: only a closing byte needs room in the output register.
  assign frame_end = (phase_r == PH_BODY) && (s1_byte_r == END_BYTE) &&
                     (prev_byte_r == END_BYTE);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_fire   = s1_valid_r && (!frame_end || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // Next phase of the frame grammar.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_KIND: begin
        if (s1_byte_r == KIND_CORNER || s1_byte_r == KIND_CURRENT) begin
          phase_nxt = PH_BODY;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (frame_end) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        if (s1_byte_r == HEADER_BYTE) begin
          phase_nxt = PH_KIND;
        end
      end
    endcase
  end

  // Body view with the terminating zero placed at the current length.
  assign len_short = body_len_r < LEN_W'(4);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      view[i] = body_r[i];
    end
    if (len_short) begin
      view[body_len_r[1:0]] = '0;
    end
  end

  assign px     = {view[0], view[1]};
  assign py     = {view[2], view[3]};
  assign cur_ok = (px != '0) && (py != '0) && (px <= x_limit_r) && (py <= y_limit_r);

  // Datapath updates per byte.
  always_comb begin
    frame_kind_nxt = frame_kind_r;
    body_len_nxt   = body_len_r;
    corner_cnt_nxt = corner_cnt_r;
    for (int i = 0; i < 4; i++) begin
      body_nxt[i] = body_r[i];
    end
    unique case (phase_r)
      PH_KIND: begin
        if (s1_byte_r == KIND_CORNER) begin
          frame_kind_nxt = KIND_BIT_CORNER;
        end else if (s1_byte_r == KIND_CURRENT) begin
          frame_kind_nxt = KIND_BIT_CURRENT;
        end
      end
      PH_BODY: begin
        if (frame_end) begin
          for (int i = 0; i < 4; i++) begin
            body_nxt[i] = view[i];
          end
          frame_kind_nxt = KIND_BIT_CURRENT;
          if (frame_kind_r == KIND_BIT_CORNER) begin
            corner_cnt_nxt = corner_cnt_r + CIDX_W'(1);
          end
        end else if (body_len_r < LEN_W'(BUFFER_BYTES - 1)) begin
          if (len_short) begin
            body_nxt[body_len_r[1:0]] = s1_byte_r;
          end
          body_len_nxt = body_len_r + LEN_W'(1);
        end
      end
      default: begin
        if (s1_byte_r == HEADER_BYTE) begin
          body_len_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      frame_kind_r <= KIND_BIT_CURRENT;
      prev_byte_r  <= '0;
      body_len_r   <= '0;
      corner_cnt_r <= '0;
      for (int i = 0; i < 4; i++) begin
        body_r[i] <= '0;
      end
    end else if (s1_fire) begin
      phase_r      <= phase_nxt;
      frame_kind_r <= frame_kind_nxt;
      prev_byte_r  <= s1_byte_r;
      body_len_r   <= body_len_nxt;
      corner_cnt_r <= corner_cnt_nxt;
      for (int i = 0; i < 4; i++) begin
        body_r[i] <= body_nxt[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && frame_end) begin
      out_x_r <= px;
      out_y_r <= py;
      if (frame_kind_r == KIND_BIT_CORNER) begin
        out_kind_r <= KIND_BIT_CORNER;
        out_acc_r  <= 1'b1;
        out_cidx_r <= corner_cnt_r;
      end else begin
        out_kind_r <= KIND_BIT_CURRENT;
        out_acc_r  <= cur_ok;
        out_cidx_r <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.point_kind   = out_kind_r;
  assign out_ch.point_x      = out_x_r;
  assign out_ch.point_y      = out_y_r;
  assign out_ch.accepted     = out_acc_r;
  assign out_ch.corner_index = out_cidx_r;

endmodule

>>> bench/pfp_point_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the point frame parser.
// Every received byte goes through a cycle-free copy of the frame grammar,
// and each finished frame leaves one expected point in a queue. Points leaving
// the block are compared field by field against the oldest entry.
module pfp_point_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  pfp_in_if                                 in_ch,
  pfp_out_if                                out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pfp_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [pfp_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  input  logic                              cfg_pready,
  output int unsigned                       mismatch_count,
  output int unsigned                       points_outstanding
);
  import pfp_pkg::*;

  localparam int unsigned PRINT_CAP = 100;

  typedef struct packed {
    logic               point_kind;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               accepted;
    logic [CIDX_W-1:0]  corner_index;
  } point_t;

  point_t expected_points[$];

  // Shadow of the parser state and its two limits.
  phase_t             phase;
  logic               corner_frame;
  logic [BYTE_W-1:0]  last_byte;
  logic [7:0]         body_len;
  logic [BYTE_W-1:0]  head_bytes [4];
  logic [CIDX_W-1:0]  corners_seen;
  logic [COORD_W-1:0] x_limit;
  logic [COORD_W-1:0] y_limit;
  int unsigned        points_seen;

  initial begin
    mismatch_count = 0;
    points_outstanding = 0;
  end

  // One line per mismatch; printing stops after PRINT_CAP mismatches but counting does not.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns: point %0d: %s got 0x%0h, want 0x%0h",
               $time, points_seen, what, got, want);
    mismatch_count++;
  endtask

  // Advance the frame grammar by one byte and queue a point when a frame closes.
  task automatic parse_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] prior;
    point_t            pt;
    prior = last_byte;
    last_byte = b;
    case (phase)
      PH_KIND: begin
        if (b == KIND_CORNER) begin
          phase = PH_BODY;
          corner_frame = 1'b1;
        end else if (b == KIND_CURRENT) begin
          phase = PH_BODY;
          corner_frame = 1'b0;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (b == END_BYTE && prior == END_BYTE) begin
          phase = PH_HUNT;
          // The terminating zero only matters when it lands in the first four bytes.
          if (body_len < 4) head_bytes[body_len[1:0]] = '0;
          pt.point_x = {head_bytes[0], head_bytes[1]};
          pt.point_y = {head_bytes[2], head_bytes[3]};
          if (corner_frame) begin
            pt.point_kind = KIND_BIT_CORNER;
            pt.accepted = 1'b1;
            pt.corner_index = corners_seen;
            corners_seen = corners_seen + 1'b1;
          end else begin
            pt.point_kind = KIND_BIT_CURRENT;
            pt.accepted = (pt.point_x != 0) && (pt.point_y != 0) &&
                          (pt.point_x <= x_limit) && (pt.point_y <= y_limit);
            pt.corner_index = '0;
          end
          corner_frame = 1'b0;
          expected_points.push_back(pt);
        end else if (body_len < BUFFER_BYTES - 1) begin
          // Bytes past the buffer end are dropped and the length saturates.
          if (body_len < 4) head_bytes[body_len[1:0]] = b;
          body_len = body_len + 1'b1;
        end
      end
      default: begin
        // Hunting: a header restarts the body but keeps the stored bytes.
        if (b == HEADER_BYTE) begin
          phase = PH_KIND;
          body_len = '0;
        end
      end
    endcase
  endtask

  // Compare one transferred point against the oldest expectation.
  task automatic check_point();
    point_t want;
    points_seen++;
    if (expected_points.size() == 0) begin
      report_mismatch("point with nothing expected, x", out_ch.point_x, '0);
    end else begin
      want = expected_points.pop_front();
      if (out_ch.point_kind !== want.point_kind)
        report_mismatch("point_kind", out_ch.point_kind, want.point_kind);
      if (out_ch.point_x !== want.point_x)
        report_mismatch("point_x", out_ch.point_x, want.point_x);
      if (out_ch.point_y !== want.point_y)
        report_mismatch("point_y", out_ch.point_y, want.point_y);
      if (out_ch.accepted !== want.accepted)
        report_mismatch("accepted", out_ch.accepted, want.accepted);
      if (out_ch.corner_index !== want.corner_index)
        report_mismatch("corner_index", out_ch.corner_index, want.corner_index);
    end
  endtask

  // A point leaving in the same cycle as a byte arrives belongs to an earlier
  // byte, so the output side is checked before the new byte is parsed.
  always @(posedge clk) begin
    if (!rst_n) begin
      phase = PH_HUNT;
      corner_frame = 1'b0;
      last_byte = '0;
      body_len = '0;
      head_bytes = '{default: '0};
      corners_seen = '0;
      x_limit = X_LIMIT_RESET;
      y_limit = Y_LIMIT_RESET;
      points_seen = 0;
      expected_points.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_X_LIMIT) x_limit = cfg_pwdata[COORD_W-1:0];
        else y_limit = cfg_pwdata[COORD_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) check_point();
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.rx_byte);
    end
    points_outstanding = expected_points.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

// Drives bytes into the point frame parser and sets its limits between phases.
// Checking lives in the point checker beside the block.
module tb;
  import pfp_pkg::*;

  localparam int unsigned PHASES          = 5;
  localparam int unsigned PHASE_BYTES     = 210;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned WATCHDOG_CYCLES = 2000;

  typedef enum int {
    ALWAYS_READY,
    HALF_READY,
    RARE_READY,
    PERIODIC_READY
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int unsigned mismatch_count;
  int unsigned points_outstanding;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;
  int          burst_left;
  logic        hold_req;
  logic [COORD_W-1:0] cur_x_limit;
  logic [COORD_W-1:0] cur_y_limit;

  pfp_in_if  in_ch ();
  pfp_out_if out_ch ();

  point_frame_parser i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pfp_point_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ch              (in_ch),
    .out_ch             (out_ch),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_pready         (cfg_pready),
    .mismatch_count     (mismatch_count),
    .points_outstanding (points_outstanding)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: too many cycles in a row without any transfer ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: stretches of different stall patterns, plus one long hold-off
  // on request so that the block fills up and stops taking bytes.
  initial begin
    sink_mode_t  mode;
    int unsigned stretch;
    int unsigned period;
    int unsigned k;
    out_ch.ready = 1'b0;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      stretch = $urandom_range(20, 200);
      period = $urandom_range(2, 6);
      for (k = 0; k < stretch; k++) begin
        @(negedge clk);
        if (hold_req) begin
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          ALWAYS_READY:   out_ch.ready <= 1'b1;
          HALF_READY:     out_ch.ready <= 1'($urandom_range(0, 1));
          RARE_READY:     out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:        out_ch.ready <= (k % period == 0);
        endcase
      end
    end
  end

  // Offer one byte and wait for its transfer. Bytes go out in bursts of
  // random length separated by random gaps.
  task automatic put_byte(input logic [BYTE_W-1:0] b, input bit counted);
    int unsigned gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (counted) bytes_sent++;
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic idx, input logic [COORD_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= APB_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_X_LIMIT) cur_x_limit = value;
    else cur_y_limit = value;
  endtask

  // Stop sending, wait for every expected point, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (points_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Coordinates cluster around zero and the active limit.
  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] lim);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return lim;
      2:       return lim + 1'b1;
      3:       return lim - 1'b1;
      4:       return COORD_W'($urandom());
      5:       return COORD_W'(1);
      default: return COORD_W'($urandom_range(0, lim));
    endcase
  endfunction

  // One frame with random content: mostly well formed, sometimes with a bad
  // kind, a short or oversized body, or no terminator at all.
  task automatic send_frame();
    logic [BYTE_W-1:0]  kind_b;
    logic [BYTE_W-1:0]  b;
    logic [BYTE_W-1:0]  prev;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    int unsigned        pick;
    int unsigned        body_n;
    int unsigned        i;
    bit                 truncated;

    // Line noise between frames.
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put_byte(BYTE_W'($urandom()), 1'b0);

    pick = $urandom_range(0, 19);
    if (pick < 9) kind_b = KIND_CORNER;
    else if (pick < 18) kind_b = KIND_CURRENT;
    else kind_b = BYTE_W'($urandom());

    pick = $urandom_range(0, 19);
    if (pick < 2) body_n = $urandom_range(0, 3);
    else if (pick == 2) body_n = $urandom_range(BUFFER_BYTES - 6, BUFFER_BYTES + 8);
    else body_n = $urandom_range(4, 7);
    truncated = ($urandom_range(0, 9) == 0);

    x = pick_coord(cur_x_limit);
    y = pick_coord(cur_y_limit);

    put_byte(HEADER_BYTE, 1'b1);
    put_byte(kind_b, 1'b1);
    prev = kind_b;
    for (i = 0; i < body_n; i++) begin
      case (i)
        0:       b = x[15:8];
        1:       b = x[7:0];
        2:       b = y[15:8];
        3:       b = y[7:0];
        default: b = BYTE_W'($urandom());
      endcase
      // Keep the body from closing the frame early.
      if (b == END_BYTE && prev == END_BYTE) b = 8'h00;
      put_byte(b, 1'b1);
      prev = b;
    end
    if (!truncated) begin
      put_byte(END_BYTE, 1'b1);
      put_byte(END_BYTE, 1'b1);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [BYTE_W-1:0] directed [22];
    int unsigned       ph;

    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    rst_n = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    bytes_sent = 0;
    burst_left = 0;
    cur_x_limit = X_LIMIT_RESET;
    cur_y_limit = Y_LIMIT_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A current point inside the limits, a corner point with a short body that
    // leaves stale bytes, a bad kind byte, and header bytes inside a body.
    directed = '{HEADER_BYTE, KIND_CURRENT, 8'h01, 8'h00, 8'h00, 8'hF0, END_BYTE, END_BYTE,
                 HEADER_BYTE, KIND_CORNER, END_BYTE, END_BYTE,
                 HEADER_BYTE, 8'h07,
                 HEADER_BYTE, KIND_CURRENT, HEADER_BYTE, HEADER_BYTE, 8'h00, 8'h05,
                 END_BYTE, END_BYTE};
    foreach (directed[i]) put_byte(directed[i], 1'b1);

    // Random frames under several limit settings, extremes included.
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            cfg_write(REG_X_LIMIT, '0);
            cfg_write(REG_Y_LIMIT, '0);
          end
          2: begin
            cfg_write(REG_X_LIMIT, '1);
            cfg_write(REG_Y_LIMIT, '1);
          end
          3: begin
            cfg_write(REG_X_LIMIT, COORD_W'($urandom()));
            cfg_write(REG_Y_LIMIT, COORD_W'($urandom()));
          end
          default: begin
            cfg_write(REG_X_LIMIT, COORD_W'($urandom_range(1, 600)));
            cfg_write(REG_Y_LIMIT, COORD_W'($urandom_range(1, 600)));
          end
        endcase
      end
      // Long hold-off on the result side while bytes keep coming.
      if (ph == 2) hold_req = 1'b1;
      while (bytes_sent < (ph + 1) * PHASE_BYTES) send_frame();
    end

    drain();
    if (mismatch_count == 0 && points_outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
rtl/core/pfp_pkg.sv
rtl/core/pfp_in_if.sv
rtl/core/pfp_out_if.sv
rtl/core/point_frame_parser.sv
bench/pfp_point_checker.sv
bench/tb.sv
